[design/geofence_radio_region_select_unit_macros.svh]
// assertion macros shared by the region select unit
`ifndef GEOFENCE_RADIO_REGION_SELECT_UNIT_MACROS_SVH
`define GEOFENCE_RADIO_REGION_SELECT_UNIT_MACROS_SVH

// property sampled on clk, off while in reset
`define GRRS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// property that must hold in the cycle after the trigger
`define GRRS_ASSERT_NEXT(label, trig, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (prop)) \
		else $error(msg);

`endif

[design/grrs_pkg.sv]
// band plan codes and box edge constants for the region select unit
package grrs_pkg;

	typedef logic [2:0] plan_t;

	localparam plan_t PLAN_SILENT = 3'd0;
	localparam plan_t PLAN_US915  = 3'd1;
	localparam plan_t PLAN_EU868  = 3'd2;
	localparam plan_t PLAN_AU915  = 3'd3;
	localparam plan_t PLAN_AS923  = 3'd4;

	typedef logic signed [31:0] coord_t;

	// whole degrees scaled by ten million
	localparam coord_t E7_0   = 32'sd0;
	localparam coord_t E7_4   = 32'sd40000000;
	localparam coord_t E7_6   = 32'sd60000000;
	localparam coord_t E7_10  = 32'sd100000000;
	localparam coord_t E7_11  = 32'sd110000000;
	localparam coord_t E7_12  = 32'sd120000000;
	localparam coord_t E7_19  = 32'sd190000000;
	localparam coord_t E7_22  = 32'sd220000000;
	localparam coord_t E7_23  = 32'sd230000000;
	localparam coord_t E7_25  = 32'sd250000000;
	localparam coord_t E7_27  = 32'sd270000000;
	localparam coord_t E7_30  = 32'sd300000000;
	localparam coord_t E7_41  = 32'sd410000000;
	localparam coord_t E7_46  = 32'sd460000000;
	localparam coord_t E7_50  = 32'sd500000000;
	localparam coord_t E7_54  = 32'sd540000000;
	localparam coord_t E7_55  = 32'sd550000000;
	localparam coord_t E7_56  = 32'sd560000000;
	localparam coord_t E7_60  = 32'sd600000000;
	localparam coord_t E7_68  = 32'sd680000000;
	localparam coord_t E7_70  = 32'sd700000000;
	localparam coord_t E7_73  = 32'sd730000000;
	localparam coord_t E7_90  = 32'sd900000000;
	localparam coord_t E7_98  = 32'sd980000000;
	localparam coord_t E7_110 = 32'sd1100000000;
	localparam coord_t E7_116 = 32'sd1160000000;
	localparam coord_t E7_123 = 32'sd1230000000;
	localparam coord_t E7_124 = 32'sd1240000000;
	localparam coord_t E7_127 = 32'sd1270000000;
	localparam coord_t E7_132 = 32'sd1320000000;
	localparam coord_t E7_140 = 32'sd1400000000;
	localparam coord_t E7_146 = 32'sd1460000000;
	localparam coord_t E7_160 = 32'sd1600000000;
	localparam coord_t E7_180 = 32'sd1800000000;

endpackage

[design/grrs_classify.sv]
// priority box tests that map one position to a band plan code
module grrs_classify (
	input  grrs_pkg::coord_t lat,
	input  grrs_pkg::coord_t lon,
	output grrs_pkg::plan_t  plan
);

	logic out_of_range;
	logic polar;
	logic americas;
	logic excl_west;
	logic eu_side;
	logic excl_east;
	logic au_box;

	always_comb begin
		out_of_range = (lat < -grrs_pkg::E7_90) || (lat > grrs_pkg::E7_90) ||
			(lon < -grrs_pkg::E7_180) || (lon > grrs_pkg::E7_180);
		polar = (lat > grrs_pkg::E7_70) || (lat < -grrs_pkg::E7_70);
		americas = lon < -grrs_pkg::E7_30;

		excl_west = (lat >= grrs_pkg::E7_55 && lon >= grrs_pkg::E7_27) ||
			(lat >= grrs_pkg::E7_41 && lon >= grrs_pkg::E7_30) ||
			(lat >= grrs_pkg::E7_54 && lat <= grrs_pkg::E7_56 &&
			 lon >= grrs_pkg::E7_19 && lon <= grrs_pkg::E7_23);

		eu_side = lon < grrs_pkg::E7_60;

		// south asia box has an exclusive north edge
		excl_east = (lat >= grrs_pkg::E7_25 && lat <= grrs_pkg::E7_55 &&
			 lon >= grrs_pkg::E7_60 && lon <= grrs_pkg::E7_132) ||
			(lat >= grrs_pkg::E7_6 && lat < grrs_pkg::E7_25 &&
			 lon >= grrs_pkg::E7_68 && lon <= grrs_pkg::E7_98) ||
			(lat >= grrs_pkg::E7_22 && lat <= grrs_pkg::E7_50 &&
			 lon >= grrs_pkg::E7_73 && lon <= grrs_pkg::E7_123) ||
			(lat >= grrs_pkg::E7_30 && lat <= grrs_pkg::E7_46 &&
			 lon >= grrs_pkg::E7_124 && lon <= grrs_pkg::E7_146) ||
			(lat >= grrs_pkg::E7_4 && lat <= grrs_pkg::E7_22 &&
			 lon >= grrs_pkg::E7_116 && lon <= grrs_pkg::E7_127) ||
			(lat >= -grrs_pkg::E7_11 && lat <= grrs_pkg::E7_0 &&
			 lon >= grrs_pkg::E7_140 && lon <= grrs_pkg::E7_160);

		au_box = (lat <= -grrs_pkg::E7_10) && (lon >= grrs_pkg::E7_110);

		if (out_of_range || polar) begin
			plan = grrs_pkg::PLAN_SILENT;
		end else if (americas) begin
			plan = (lat > grrs_pkg::E7_12) ? grrs_pkg::PLAN_US915 : grrs_pkg::PLAN_SILENT;
		end else if (excl_west) begin
			plan = grrs_pkg::PLAN_SILENT;
		end else if (eu_side) begin
			plan = grrs_pkg::PLAN_EU868;
		end else if (excl_east) begin
			plan = grrs_pkg::PLAN_SILENT;
		end else if (au_box) begin
			plan = grrs_pkg::PLAN_AU915;
		end else begin
			plan = grrs_pkg::PLAN_AS923;
		end
	end

endmodule

[design/geofence_radio_region_select_unit.sv]
// top level: position in, band plan code out, two register stages
// Usage: the input channel carries one position beat (latitude_e7,
// longitude_e7, signed degrees times ten million) under in_valid/in_stall;
// the output channel carries one band_plan beat under out_valid/out_stall.
// A beat is taken on a rising edge with valid high and stall low.
// Each position is captured in an input register, classified combinationally
// by constant box compares, and held in a result register: out_valid rises
// once the beat has moved from the input register into the result register;
// throughput is one position per cycle while out_stall is low, set by the
// single compare-and-select stage between the registers.
// Reset (arst_n low) empties both stages; no other state exists, so the
// block accepts a beat as soon as reset is released.
// When the receiver stalls, the result register holds its beat and the
// input register still takes one more position; in_stall rises only once
// both stages are full, and it drops as soon as the result moves on.
module geofence_radio_region_select_unit (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic signed [31:0]      latitude_e7,
	input  logic signed [31:0]      longitude_e7,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [2:0]              band_plan
);

	logic             valid_s1;
	grrs_pkg::coord_t lat_s1;
	grrs_pkg::coord_t lon_s1;
	logic             valid_s2;
	grrs_pkg::plan_t  plan_s2;
	grrs_pkg::plan_t  plan_next;
	logic             adv_s2;
	logic             adv_s1;

	// a stage moves when it is empty or its beat leaves this cycle
	assign adv_s2   = !(valid_s2 && out_stall);
	assign adv_s1   = !(valid_s1 && !adv_s2);
	assign in_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			lat_s1 <= latitude_e7;
			lon_s1 <= longitude_e7;
		end
	end

	grrs_classify u_classify (
		.lat  (lat_s1),
		.lon  (lon_s1),
		.plan (plan_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			plan_s2 <= plan_next;
		end
	end

	assign out_valid = valid_s2;
	assign band_plan = plan_s2;

`include "geofence_radio_region_select_unit_macros.svh"

	`GRRS_ASSERT(a_plan_range, !out_valid || (band_plan <= grrs_pkg::PLAN_AS923),
		"band plan code out of range")
	`GRRS_ASSERT(a_stall_only_full, !in_stall || (valid_s1 && valid_s2 && out_stall),
		"input stalled while a stage is free")
	`GRRS_ASSERT_NEXT(a_s1_to_s2, valid_s1 && adv_s2, out_valid,
		"beat lost between stages")

endmodule
